@@ hdl/bb3_pkg.sv @@
package bb3_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;
    localparam logic [10:0] GRID_WIDTH_RST  = 11'd1024;
    localparam logic [15:0] GRID_HEIGHT_RST = 16'd1024;

    localparam logic ACT_FLUSH = 1'b1;

    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam int COL_SUM_W   = 18;
    localparam int SUM_W       = 20;
    localparam int NUM_W       = 19;
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 23;

    typedef struct packed {
        logic               action;
        logic signed [15:0] sample;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] smoothed;
        logic [9:0]         out_col;
        logic [15:0]        out_row;
        logic               frame_last;
        logic               run_last;
    } t_out_word;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum0;
        logic [3:0]              cnt0;
        logic                    has0;
        logic [9:0]              col0;
        logic signed [SUM_W-1:0] sum1;
        logic [3:0]              cnt1;
        logic                    has1;
        logic [9:0]              col1;
        logic [15:0]             row;
        logic                    flast1;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_head;

    typedef struct packed {
        logic [Q_AW:0] free;
    } t_q_stat;

    // ceil(2^23 / d), exact for numerators below 2^19
    function automatic logic [RECIP_W-1:0] recip_of(input logic [3:0] d);
        logic [RECIP_W-1:0] r;
        case (d)
            4'd1: r = 24'd8388608;
            4'd2: r = 24'd4194304;
            4'd3: r = 24'd2796203;
            4'd4: r = 24'd2097152;
            4'd6: r = 24'd1398102;
            4'd9: r = 24'd932068;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/bb3_front.sv @@
module bb3_front #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  bb3_pkg::t_in_word                i_in_word,
    input  logic                             i_cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  bb3_pkg::t_q_stat                 i_q_stat,
    output bb3_pkg::t_push                   o_push
);
    import bb3_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [10:0]   r_cfg_w;
    logic [15:0]   r_cfg_h;
    logic [AW-1:0] r_col;
    logic [15:0]   r_row;

    logic [AW-1:0] w_last;
    logic [15:0]   h_eff;
    logic [AW-1:0] col_in;
    logic [15:0]   row_in;
    logic [AW-1:0] n_col;
    logic [15:0]   n_row;
    logic          flush_in;
    logic          ignore;
    logic          acc;
    logic          take;
    logic          lastc;

    // line stores, no reset
    logic signed [15:0] r_line_above  [MAX_WIDTH];
    logic signed [15:0] r_line_center [MAX_WIDTH];
    logic signed [15:0] r_q_above;
    logic signed [15:0] r_q_center;
    logic               r_byp;
    logic signed [15:0] r_byp_above;
    logic signed [15:0] r_byp_center;

    logic               r_v1;
    logic [AW-1:0]      r_s1_c;
    logic [15:0]        r_s1_r;
    logic               r_s1_flush;
    logic signed [15:0] r_s1_down;
    logic               r_s1_lastc;

    logic signed [15:0]          up;
    logic signed [15:0]          mid;
    logic                        up_ok;
    logic                        down_ok;
    logic                        s1_wr;
    logic signed [COL_SUM_W-1:0] up_term;
    logic signed [COL_SUM_W-1:0] dn_term;
    logic signed [COL_SUM_W-1:0] col_c;
    logic [1:0]                  cc;

    logic signed [COL_SUM_W-1:0] r_col1;
    logic signed [COL_SUM_W-1:0] r_col2;

    logic                        r_v2;
    logic signed [COL_SUM_W-1:0] r_s2_a;
    logic signed [COL_SUM_W-1:0] r_s2_b;
    logic signed [COL_SUM_W-1:0] r_s2_c;
    logic [1:0]                  r_s2_cc;
    logic                        r_s2_has0;
    logic                        r_s2_has1;
    logic                        r_s2_use_a;
    logic                        r_s2_use_b;
    logic [9:0]                  r_s2_col0;
    logic [9:0]                  r_s2_col1;
    logic [15:0]                 r_s2_row;
    logic                        r_s2_flast;

    logic signed [SUM_W-1:0] a_term;
    logic signed [SUM_W-1:0] b_term;
    logic signed [SUM_W-1:0] b1_term;
    logic signed [SUM_W-1:0] c_term;

    // ---- accept and position ----
    always_comb begin
        if (r_cfg_w == '0) begin
            w_last = '0;
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            w_last = AW'(MAX_WIDTH - 1);
        end else begin
            w_last = AW'(r_cfg_w - 11'd1);
        end
    end

    assign h_eff    = (r_cfg_h == '0) ? 16'd1 : r_cfg_h;
    assign col_in   = (r_col > w_last) ? '0 : r_col;
    assign row_in   = (r_row > h_eff) ? '0 : r_row;
    assign flush_in = (i_in_word.action == ACT_FLUSH);
    assign ignore   = flush_in != (row_in == h_eff);
    assign lastc    = (col_in == w_last);

    assign o_in_stall = (i_q_stat.free <= (Q_AW+1)'({1'b0, r_v1} + {1'b0, r_v2}));
    assign acc        = i_in_valid && !o_in_stall;
    assign take       = acc && !ignore;

    always_comb begin
        n_col = AW'(col_in + 1'b1);
        n_row = row_in;
        if (lastc) begin
            n_col = '0;
            n_row = flush_in ? '0 : (row_in + 16'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= GRID_WIDTH_RST;
            r_cfg_h <= GRID_HEIGHT_RST;
            r_col   <= '0;
            r_row   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRID_WIDTH: begin
                    r_cfg_w <= i_cfg_data[10:0];
                    r_col   <= '0;
                    r_row   <= '0;
                end
                CFG_GRID_HEIGHT: begin
                    r_cfg_h <= i_cfg_data[15:0];
                    r_col   <= '0;
                    r_row   <= '0;
                end
                default: begin
                end
            endcase
        end else if (take) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---- line stores ----
    assign s1_wr = r_v1 && !r_s1_flush;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_q_above  <= r_line_above[col_in];
            r_q_center <= r_line_center[col_in];
        end
        if (s1_wr) begin
            r_line_above[r_s1_c]  <= mid;
            r_line_center[r_s1_c] <= r_s1_down;
        end
    end

    // write of the same column in the same cycle (one-wide grid)
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byp        <= s1_wr && (r_s1_c == col_in);
            r_byp_above  <= mid;
            r_byp_center <= r_s1_down;
        end
    end

    // ---- stage 1: column sums ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_c     <= col_in;
            r_s1_r     <= row_in;
            r_s1_flush <= flush_in;
            r_s1_down  <= i_in_word.sample;
            r_s1_lastc <= lastc;
        end
    end

    assign up      = r_byp ? r_byp_above : r_q_above;
    assign mid     = r_byp ? r_byp_center : r_q_center;
    assign up_ok   = (r_s1_r >= 16'd2);
    assign down_ok = !r_s1_flush;

    always_comb begin
        up_term = '0;
        dn_term = '0;
        if (up_ok) begin
            up_term = COL_SUM_W'(up);
        end
        if (down_ok) begin
            dn_term = COL_SUM_W'(r_s1_down);
        end
        col_c = COL_SUM_W'(mid) + up_term + dn_term;
        cc    = 2'd1 + {1'b0, up_ok} + {1'b0, down_ok};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col1 <= '0;
            r_col2 <= '0;
        end else if (i_cfg_we) begin
            r_col1 <= '0;
            r_col2 <= '0;
        end else if (r_v1) begin
            r_col2 <= r_col1;
            r_col1 <= col_c;
        end
    end

    // ---- stage 2: window sums ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_s2_a     <= r_col2;
            r_s2_b     <= r_col1;
            r_s2_c     <= col_c;
            r_s2_cc    <= cc;
            r_s2_has0  <= (r_s1_r != '0) && (r_s1_c != '0);
            r_s2_has1  <= (r_s1_r != '0) && r_s1_lastc;
            r_s2_use_a <= (r_s1_c >= AW'(2));
            r_s2_use_b <= (r_s1_c != '0);
            r_s2_col0  <= 10'(r_s1_c - 1'b1);
            r_s2_col1  <= 10'(r_s1_c);
            r_s2_row   <= r_s1_r - 16'd1;
            r_s2_flast <= r_s1_flush;
        end
    end

    always_comb begin
        a_term  = '0;
        b1_term = '0;
        b_term  = SUM_W'(r_s2_b);
        c_term  = SUM_W'(r_s2_c);
        if (r_s2_use_a) begin
            a_term = SUM_W'(r_s2_a);
        end
        if (r_s2_use_b) begin
            b1_term = SUM_W'(r_s2_b);
        end
        o_push.valid       = r_v2 && (r_s2_has0 || r_s2_has1);
        o_push.job.sum0    = a_term + b_term + c_term;
        o_push.job.cnt0    = 4'(r_s2_cc) * (r_s2_use_a ? 4'd3 : 4'd2);
        o_push.job.has0    = r_s2_has0;
        o_push.job.col0    = r_s2_col0;
        o_push.job.sum1    = b1_term + c_term;
        o_push.job.cnt1    = 4'(r_s2_cc) * (r_s2_use_b ? 4'd2 : 4'd1);
        o_push.job.has1    = r_s2_has1;
        o_push.job.col1    = r_s2_col1;
        o_push.job.row     = r_s2_row;
        o_push.job.flast1  = r_s2_flast;
    end

endmodule

@@ hdl/bb3_queue.sv @@
module bb3_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bb3_pkg::t_push    i_push,
    input  logic              i_pop,
    output bb3_pkg::t_head    o_head,
    output bb3_pkg::t_q_stat  o_stat
);
    import bb3_pkg::*;

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_cnt;
    logic            pop;

    assign pop          = i_pop && (r_cnt != '0);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.job   = r_mem[r_rp];
    assign o_stat.free  = (Q_AW+1)'(Q_DEPTH) - r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wp] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push.valid, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ hdl/bb3_back.sv @@
module bb3_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bb3_pkg::t_head     i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bb3_pkg::t_out_word o_out_word
);
    import bb3_pkg::*;

    localparam int PROD_W = NUM_W + RECIP_W;
    localparam int QUO_W  = 17;

    typedef struct packed {
        logic [9:0]  col;
        logic [15:0] row;
        logic        flast;
        logic        rlast;
    } t_meta;

    logic en;
    logic sel2;
    logic r_half;

    logic signed [SUM_W-1:0] sum;
    logic [3:0]              cnt;
    logic                    neg;
    logic [SUM_W-1:0]        mag;
    logic [NUM_W-1:0]        num;
    t_meta                   meta;

    logic               r_v1;
    logic               r_b1_neg;
    logic [NUM_W-1:0]   r_b1_num;
    logic [RECIP_W-1:0] r_b1_recip;
    t_meta              r_b1_meta;

    logic               r_v2;
    logic               r_b2_neg;
    logic [PROD_W-1:0]  r_b2_prod;
    t_meta              r_b2_meta;

    logic [QUO_W-1:0]   quo;
    logic [QUO_W-1:0]   val;

    logic               r_ov;
    t_out_word          r_out;

    assign en   = !r_ov || !i_out_stall;
    assign sel2 = r_half || !i_head.job.has0;

    always_comb begin
        if (sel2) begin
            sum       = i_head.job.sum1;
            cnt       = i_head.job.cnt1;
            meta.col  = i_head.job.col1;
        end else begin
            sum       = i_head.job.sum0;
            cnt       = i_head.job.cnt0;
            meta.col  = i_head.job.col0;
        end
        meta.row   = i_head.job.row;
        meta.flast = sel2 && i_head.job.flast1;
        meta.rlast = sel2 || !i_head.job.has1;
        neg        = sum[SUM_W-1];
        mag        = neg ? (SUM_W'(0) - sum) : sum;
        // round half away from zero on the magnitude
        num        = NUM_W'(mag) + NUM_W'(cnt >> 1);
    end

    assign o_pop = i_head.valid && en && (sel2 || !i_head.job.has1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_ov   <= 1'b0;
        end else if (en) begin
            if (i_head.valid) begin
                r_half <= !o_pop;
            end
            r_v1 <= i_head.valid;
            r_v2 <= r_v1;
            r_ov <= r_v2;
        end
    end

    // reciprocal multiply
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b1_neg   <= neg;
            r_b1_num   <= num;
            r_b1_recip <= recip_of(cnt);
            r_b1_meta  <= meta;
            r_b2_neg   <= r_b1_neg;
            r_b2_prod  <= PROD_W'(r_b1_num) * PROD_W'(r_b1_recip);
            r_b2_meta  <= r_b1_meta;
        end
    end

    assign quo = r_b2_prod[RECIP_SHIFT +: QUO_W];
    assign val = r_b2_neg ? (QUO_W'(0) - quo) : quo;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.smoothed   <= val[15:0];
            r_out.out_col    <= r_b2_meta.col;
            r_out.out_row    <= r_b2_meta.row;
            r_out.frame_last <= r_b2_meta.flast;
            r_out.run_last   <= r_b2_meta.rlast;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;

endmodule

@@ hdl/box_blur_3x3_edge_aware_top.sv @@
// Path: a result word passes front stages 1 and 2, the job queue, the back
// multiply registers and the output register; a word may give a second result after it.
// Throughput: one input word per cycle unless o_in_stall; the output port gives
// one result per cycle unless i_out_stall; the 8-entry job queue takes row-end extras.
// Reset (synchronous, active low) clears counters, window and queue and sets
// width and height to 1024; the line stores are not cleared.
module box_blur_3x3_edge_aware_top #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  bb3_pkg::t_in_word              i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output bb3_pkg::t_out_word             o_out_word,
    input  logic                           i_cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bb3_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bb3_pkg::*;

    t_push   push;
    t_head   head;
    t_q_stat q_stat;
    logic    pop;

    bb3_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_stat   (q_stat),
        .o_push     (push)
    );

    bb3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    bb3_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule
